// ----- sv/ame_pkg.sv -----
// shared types and constants for the autorange meter engine
package ame_pkg;

    localparam int SAMPLE_W             = 24;
    localparam int SAMPLE_FRACTION_BITS = 23;
    localparam int VALUE_W              = 32;
    localparam int OUT_TDATA_W          = 48;

    localparam int GAIN_FIRST_W     = 4;
    localparam int GAIN_SECOND_W    = 2;
    localparam int EXCITATION_W     = 3;
    localparam int MAX_GAIN_FIRST   = 9;
    localparam int MAX_GAIN_SECOND  = 3;
    localparam int MAX_EXCITATION   = 5;
    localparam int MIN_EXCITATION   = 1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 23;
    localparam int THR_W      = 23;
    localparam int REF_W      = 20;
    localparam int FS_W       = 22;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_THR    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THR   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_REF        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_SCALE = 3'd4;

    localparam logic [THR_W-1:0] LOW_THR_RESET    = 23'd2516583;
    localparam logic [THR_W-1:0] HIGH_THR_RESET   = 23'd5872025;
    localparam logic [REF_W-1:0] REF_RESET        = 20'd100000;
    localparam logic [FS_W-1:0]  FULL_SCALE_RESET = 22'd1200000;

    // multiplier and divider sizes
    localparam int MUL_A_W    = SAMPLE_W + 1;
    localparam int MUL_B_W    = FS_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int REF_PROD_W = SAMPLE_W + REF_W;
    localparam int SHIFT_W    = 4;
    localparam int DIVIDEND_W = REF_PROD_W + (1 << SHIFT_W) - 1;
    localparam int DIVISOR_W  = SAMPLE_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

    localparam logic [VALUE_W-1:0] SAT_VALUE = 32'h7fff_ffff;

    typedef enum logic [1:0] {
        MODE_VOLT_AUTO,
        MODE_RES_AUTO,
        MODE_RES_SHORT,
        MODE_RES_OPEN
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div_init;
        logic div_step;
        logic finish;
    } ame_cmd_t;

    typedef struct packed {
        logic ratio_op;
        logic div_last;
    } ame_sts_t;

endpackage

// ----- sv/autorange_meter_engine.sv -----
// autorange meter engine top level: stream ports, config port, control and datapath
// voltage items and first samples of a pair: capture, multiply, result register;
//   a second sample adds divider setup and the 59-step one-bit-per-cycle ratio divider
// a new item is taken only after the last result is loaded into a free output register
// a finished result waits in the output register while the next item is taken
// reset: synchronous active-low, config returns to defaults, gains 0, excitation 5
module autorange_meter_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ame_pkg::SAMPLE_W-1:0]        s_tdata,   // sample
    input  logic                                s_tuser,   // overrange
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // value, next_gain_first, next_gain_second, next_excitation, next_phase, zero pad
    output logic [ame_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser,   // over
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [ame_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ame_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    ame_pkg::ame_cmd_t cmd;
    ame_pkg::ame_sts_t sts;

    ame_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ame_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_sample    (s_tdata),
        .in_overrange (s_tuser),
        .cmd          (cmd),
        .sts          (sts),
        .out_data     (m_tdata),
        .out_over     (m_tuser),
        .out_last     (m_tlast)
    );

endmodule

// ----- sv/ame_ctrl.sv -----
// sequencing state machine and output valid for the autorange meter engine
module ame_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  ame_pkg::ame_sts_t sts,
    output ame_pkg::ame_cmd_t cmd
);

    ame_pkg::state_t state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ame_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ame_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ame_pkg::ST_MUL;
                end
            end
            ame_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = sts.ratio_op ? ame_pkg::ST_PREP : ame_pkg::ST_DONE;
            end
            ame_pkg::ST_PREP: begin
                cmd.div_init = 1'b1;
                state_next   = ame_pkg::ST_DIV;
            end
            ame_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ame_pkg::ST_DONE;
                end
            end
            ame_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.finish    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ame_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ame_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ame_pkg::ST_MUL)
        else $error("accepted item did not start the multiply");

    a_finish_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over an untaken result");

    a_div_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ame_pkg::ST_DIV && $past(state_reg) != ame_pkg::ST_DIV
        |-> $past(state_reg) == ame_pkg::ST_PREP)
        else $error("divide entered without setup");

endmodule

// ----- sv/ame_dp.sv -----
// datapath: config, range state, shared multiplier, serial divider, result register
module ame_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ame_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ame_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [ame_pkg::SAMPLE_W-1:0]        in_sample,
    input  logic                                in_overrange,
    input  ame_pkg::ame_cmd_t                   cmd,
    output ame_pkg::ame_sts_t                   sts,
    output logic [ame_pkg::OUT_TDATA_W-1:0]     out_data,
    output logic                                out_over,
    output logic                                out_last
);

    // configuration
    ame_pkg::mode_t                   mode_reg;
    logic [ame_pkg::THR_W-1:0]        low_thr_reg, high_thr_reg;
    logic [ame_pkg::REF_W-1:0]        ref_reg;
    logic [ame_pkg::FS_W-1:0]         fs_reg;

    // range and pairing state
    logic                                phase_reg, phase_next;
    logic [ame_pkg::SAMPLE_W-1:0]        held_sample_reg, held_sample_next;
    logic                                held_over_reg, held_over_next;
    logic [ame_pkg::GAIN_FIRST_W-1:0]    agf_reg, agf_next, pgf_reg, pgf_next;
    logic [ame_pkg::GAIN_SECOND_W-1:0]   ags_reg, ags_next, pgs_reg, pgs_next;
    logic [ame_pkg::EXCITATION_W-1:0]    pexc_reg, pexc_next;

    // current item and arithmetic
    logic [ame_pkg::SAMPLE_W-1:0]        sample_reg;
    logic                                ovr_reg;
    logic signed [ame_pkg::PROD_W-1:0]   prod_reg;
    logic [ame_pkg::DIVIDEND_W-1:0]      quo_reg;
    logic [ame_pkg::DIVISOR_W-1:0]       rem_reg, dvs_reg;
    logic                                neg_reg;
    logic [ame_pkg::DIV_CNT_W-1:0]       cnt_reg;

    logic [ame_pkg::OUT_TDATA_W-1:0]     out_data_reg;
    logic                                out_over_reg, out_last_reg;

    logic                                clr;
    logic                                ratio_op;
    logic [ame_pkg::SAMPLE_W-1:0]        smp_mag, held_mag, dvs_in;
    logic                                low, high;
    logic signed [ame_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [ame_pkg::MUL_B_W-1:0]  mul_b;
    logic [ame_pkg::SHIFT_W-1:0]         up_sh, down_sh;
    logic [ame_pkg::DIVIDEND_W-1:0]      dividend;
    logic [ame_pkg::DIVISOR_W:0]         trial, diff;
    logic                                trial_ge;
    logic [ame_pkg::DIVIDEND_W-1:0]      q_sh, frac_mask;
    logic                                round_up;
    logic [ame_pkg::DIVIDEND_W:0]        res_mag;
    logic                                res_over;
    logic [ame_pkg::VALUE_W-1:0]         res_value;
    logic [5:0]                          volt_sh;
    logic signed [ame_pkg::PROD_W-1:0]   volt_full;
    logic [ame_pkg::VALUE_W-1:0]         value;
    logic                                over, ready_res;
    logic [ame_pkg::GAIN_FIRST_W-1:0]    g1;
    logic [ame_pkg::GAIN_SECOND_W-1:0]   g2;
    logic [ame_pkg::EXCITATION_W-1:0]    exc;

    assign clr = cfg_we && (cfg_addr == ame_pkg::REG_MODE)
              && (cfg_wdata[1:0] != mode_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= ame_pkg::MODE_VOLT_AUTO;
            low_thr_reg  <= ame_pkg::LOW_THR_RESET;
            high_thr_reg <= ame_pkg::HIGH_THR_RESET;
            ref_reg      <= ame_pkg::REF_RESET;
            fs_reg       <= ame_pkg::FULL_SCALE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ame_pkg::REG_MODE:       mode_reg     <= ame_pkg::mode_t'(cfg_wdata[1:0]);
                ame_pkg::REG_LOW_THR:    low_thr_reg  <= cfg_wdata[ame_pkg::THR_W-1:0];
                ame_pkg::REG_HIGH_THR:   high_thr_reg <= cfg_wdata[ame_pkg::THR_W-1:0];
                ame_pkg::REG_REF:        ref_reg      <= cfg_wdata[ame_pkg::REF_W-1:0];
                ame_pkg::REG_FULL_SCALE: fs_reg       <= cfg_wdata[ame_pkg::FS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // magnitudes and range decisions
    assign smp_mag  = sample_reg[ame_pkg::SAMPLE_W-1] ? ame_pkg::SAMPLE_W'(-sample_reg)
                                                      : sample_reg;
    assign held_mag = held_sample_reg[ame_pkg::SAMPLE_W-1]
                    ? ame_pkg::SAMPLE_W'(-held_sample_reg) : held_sample_reg;
    assign low  = smp_mag < {1'b0, low_thr_reg};
    assign high = smp_mag > {1'b0, high_thr_reg};
    assign ratio_op = (mode_reg != ame_pkg::MODE_VOLT_AUTO) && phase_reg;

    // shared multiplier: sample times full scale, or held magnitude times reference
    assign mul_a = ratio_op ? $signed({1'b0, held_mag})
                            : $signed({sample_reg[ame_pkg::SAMPLE_W-1], sample_reg});
    assign mul_b = ratio_op ? $signed({(ame_pkg::MUL_B_W - ame_pkg::REF_W)'(0), ref_reg})
                            : $signed({1'b0, fs_reg});

    always_comb begin
        unique case (mode_reg)
            ame_pkg::MODE_RES_AUTO: begin
                up_sh   = {(ame_pkg::SHIFT_W - ame_pkg::GAIN_SECOND_W)'(0), ags_reg};
                down_sh = agf_reg;
            end
            ame_pkg::MODE_RES_SHORT: begin
                up_sh   = ame_pkg::SHIFT_W'(ame_pkg::MAX_GAIN_SECOND);
                down_sh = ame_pkg::SHIFT_W'(ame_pkg::MAX_GAIN_FIRST);
            end
            ame_pkg::MODE_RES_OPEN: begin
                up_sh   = ame_pkg::SHIFT_W'(ame_pkg::MAX_GAIN_FIRST);
                down_sh = '0;
            end
            ame_pkg::MODE_VOLT_AUTO: begin
                up_sh   = '0;
                down_sh = '0;
            end
            default: begin
                up_sh   = '0;
                down_sh = '0;
            end
        endcase
    end

    assign dividend = ame_pkg::DIVIDEND_W'(prod_reg[ame_pkg::REF_PROD_W-1:0]) << up_sh;
    assign dvs_in   = (sample_reg == '0) ? ame_pkg::DIVISOR_W'(1) : smp_mag;

    // one quotient bit per step
    assign trial    = {rem_reg, quo_reg[ame_pkg::DIVIDEND_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign trial_ge = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= in_sample;
            ovr_reg    <= in_overrange;
        end
        if (cmd.mul) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.div_init) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= dvs_in;
            neg_reg <= held_sample_reg[ame_pkg::SAMPLE_W-1] ^ sample_reg[ame_pkg::SAMPLE_W-1];
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[ame_pkg::DIVIDEND_W-2:0], trial_ge};
            rem_reg <= trial_ge ? diff[ame_pkg::DIVISOR_W-1:0] : trial[ame_pkg::DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_init) begin
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // floor shift of the signed quotient, then magnitude
    assign q_sh      = quo_reg >> down_sh;
    assign frac_mask = ~({ame_pkg::DIVIDEND_W{1'b1}} << down_sh);
    assign round_up  = neg_reg && ((quo_reg & frac_mask) != '0);
    assign res_mag   = {1'b0, q_sh} + (ame_pkg::DIVIDEND_W + 1)'(round_up);
    assign res_over  = held_over_reg || (res_mag[ame_pkg::DIVIDEND_W:ame_pkg::VALUE_W] != '0);
    assign res_value = res_over ? ame_pkg::SAT_VALUE : res_mag[ame_pkg::VALUE_W-1:0];

    assign volt_sh   = 6'(ame_pkg::SAMPLE_FRACTION_BITS) + {2'b00, agf_reg};
    assign volt_full = prod_reg >>> volt_sh;

    // range state for the next item
    always_comb begin
        phase_next       = phase_reg;
        held_sample_next = held_sample_reg;
        held_over_next   = held_over_reg;
        agf_next         = agf_reg;
        ags_next         = ags_reg;
        pgf_next         = pgf_reg;
        pgs_next         = pgs_reg;
        pexc_next        = pexc_reg;
        if (mode_reg == ame_pkg::MODE_VOLT_AUTO) begin
            if (low) begin
                if (pgf_reg < ame_pkg::GAIN_FIRST_W'(ame_pkg::MAX_GAIN_FIRST)) begin
                    pgf_next = pgf_reg + 1'b1;
                end
            end else if (high) begin
                if (pgf_reg != '0) begin
                    pgf_next = pgf_reg - 1'b1;
                end
            end
            agf_next   = pgf_next;
            phase_next = 1'b0;
        end else if (!phase_reg) begin
            held_sample_next = sample_reg;
            held_over_next   = ovr_reg;
            phase_next       = 1'b1;
            if (mode_reg == ame_pkg::MODE_RES_AUTO) begin
                if (low) begin
                    if (pexc_reg >= ame_pkg::EXCITATION_W'(ame_pkg::MAX_EXCITATION)) begin
                        if (pgf_reg < ame_pkg::GAIN_FIRST_W'(ame_pkg::MAX_GAIN_FIRST)) begin
                            pgf_next = pgf_reg + 1'b1;
                        end
                    end else begin
                        pexc_next = pexc_reg + 1'b1;
                    end
                end else if (high) begin
                    if (pgf_reg == '0) begin
                        if (pexc_reg > ame_pkg::EXCITATION_W'(ame_pkg::MIN_EXCITATION)) begin
                            pexc_next = pexc_reg - 1'b1;
                        end
                    end else begin
                        pgf_next = pgf_reg - 1'b1;
                    end
                end
            end
        end else begin
            phase_next = 1'b0;
            if (mode_reg == ame_pkg::MODE_RES_AUTO) begin
                if (low) begin
                    if (pgs_reg < ame_pkg::GAIN_SECOND_W'(ame_pkg::MAX_GAIN_SECOND)) begin
                        pgs_next = pgs_reg + 1'b1;
                    end
                end else if (high) begin
                    if (pgs_reg != '0) begin
                        pgs_next = pgs_reg - 1'b1;
                    end
                end
                agf_next = pgf_reg;
                ags_next = pgs_next;
            end
        end
    end

    // result fields
    always_comb begin
        if (mode_reg == ame_pkg::MODE_VOLT_AUTO) begin
            value     = volt_full[ame_pkg::VALUE_W-1:0];
            over      = ovr_reg;
            ready_res = 1'b1;
        end else if (phase_reg) begin
            value     = res_value;
            over      = res_over;
            ready_res = 1'b1;
        end else begin
            value     = '0;
            over      = 1'b0;
            ready_res = 1'b0;
        end
        unique case (mode_reg)
            ame_pkg::MODE_RES_AUTO: begin
                g1  = pgf_next;
                g2  = pgs_next;
                exc = pexc_next;
            end
            ame_pkg::MODE_RES_SHORT: begin
                g1  = ame_pkg::GAIN_FIRST_W'(ame_pkg::MAX_GAIN_FIRST);
                g2  = ame_pkg::GAIN_SECOND_W'(ame_pkg::MAX_GAIN_SECOND);
                exc = ame_pkg::EXCITATION_W'(ame_pkg::MAX_EXCITATION);
            end
            ame_pkg::MODE_RES_OPEN: begin
                g1  = phase_next ? ame_pkg::GAIN_FIRST_W'(ame_pkg::MAX_GAIN_FIRST) : '0;
                g2  = '0;
                exc = '0;
            end
            ame_pkg::MODE_VOLT_AUTO: begin
                g1  = pgf_next;
                g2  = '0;
                exc = '0;
            end
            default: begin
                g1  = '0;
                g2  = '0;
                exc = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            phase_reg       <= 1'b0;
            held_sample_reg <= '0;
            held_over_reg   <= 1'b0;
            agf_reg         <= '0;
            ags_reg         <= '0;
            pgf_reg         <= '0;
            pgs_reg         <= '0;
            pexc_reg        <= ame_pkg::EXCITATION_W'(ame_pkg::MAX_EXCITATION);
        end else if (cmd.finish) begin
            phase_reg       <= phase_next;
            held_sample_reg <= held_sample_next;
            held_over_reg   <= held_over_next;
            agf_reg         <= agf_next;
            ags_reg         <= ags_next;
            pgf_reg         <= pgf_next;
            pgs_reg         <= pgs_next;
            pexc_reg        <= pexc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg <= {(ame_pkg::OUT_TDATA_W - 42)'(0), phase_next, exc, g2, g1, value};
            out_over_reg <= over;
            out_last_reg <= ready_res;
        end
    end

    assign sts.ratio_op = ratio_op;
    assign sts.div_last = cnt_reg == ame_pkg::DIV_LAST;
    assign out_data     = out_data_reg;
    assign out_over     = out_over_reg;
    assign out_last     = out_last_reg;

    a_gain_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        pgf_reg <= ame_pkg::GAIN_FIRST_W'(ame_pkg::MAX_GAIN_FIRST)
        && pgs_reg <= ame_pkg::GAIN_SECOND_W'(ame_pkg::MAX_GAIN_SECOND))
        else $error("pending gain out of range");

    a_excitation_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        pexc_reg >= ame_pkg::EXCITATION_W'(ame_pkg::MIN_EXCITATION)
        && pexc_reg <= ame_pkg::EXCITATION_W'(ame_pkg::MAX_EXCITATION))
        else $error("pending excitation out of range");

endmodule

// ----- verif/autorange_meter_engine_tb.sv -----
// self-checking testbench for the autorange meter engine, with its own reading predictor
module autorange_meter_engine_tb;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 80;
    localparam int LONG_HOLD     = 300;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 78;
    localparam logic [ame_pkg::CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [ame_pkg::VALUE_W-1:0]       value;
        logic                              over;
        logic                              ready;
        logic [ame_pkg::GAIN_FIRST_W-1:0]  g1;
        logic [ame_pkg::GAIN_SECOND_W-1:0] g2;
        logic [ame_pkg::EXCITATION_W-1:0]  exc;
        logic                              ph;
    } reading_t;

    typedef struct {
        logic                         wr_mode;
        ame_pkg::mode_t               mode;
        logic [ame_pkg::SAMPLE_W-1:0] smp;
        logic                         ovr;
        logic                         known;
        reading_t                     typed;
    } stim_row_t;

    localparam reading_t NO_READING = '0;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ame_pkg::SAMPLE_W-1:0]    s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [ame_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;
    logic                            cfg_we;
    logic [ame_pkg::CFG_ADDR_W-1:0]  cfg_addr;
    logic [ame_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    autorange_meter_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // predictor state
    ame_pkg::mode_t cfg_mode;
    longint  cfg_low, cfg_high, cfg_ref, cfg_fs;
    logic    pair_phase;
    longint  held_sample;
    logic    held_over;
    int      gain_first_applied, gain_second_applied;
    int      gain_first_next, gain_second_next, excitation_next;

    reading_t  pending_readings[$];
    stim_row_t stim_rows[$];
    bit        idle_on;
    int        errors, items_sent, results_checked, readings_done, reg_writes;
    int        cycle_count;

    function automatic void meter_clear();
        pair_phase          = 1'b0;
        held_sample         = 0;
        held_over           = 1'b0;
        gain_first_applied  = 0;
        gain_second_applied = 0;
        gain_first_next     = 0;
        gain_second_next    = 0;
        excitation_next     = ame_pkg::MAX_EXCITATION;
    endfunction

    function automatic void meter_cfg(input logic [ame_pkg::CFG_ADDR_W-1:0] addr,
                                      input logic [ame_pkg::CFG_DATA_W-1:0] data);
        case (addr)
            ame_pkg::REG_MODE: begin
                if (ame_pkg::mode_t'(data[1:0]) != cfg_mode) begin
                    cfg_mode = ame_pkg::mode_t'(data[1:0]);
                    meter_clear();
                end
            end
            ame_pkg::REG_LOW_THR:    cfg_low  = data[ame_pkg::THR_W-1:0];
            ame_pkg::REG_HIGH_THR:   cfg_high = data[ame_pkg::THR_W-1:0];
            ame_pkg::REG_REF:        cfg_ref  = data[ame_pkg::REF_W-1:0];
            ame_pkg::REG_FULL_SCALE: cfg_fs   = data[ame_pkg::FS_W-1:0];
            default: ;
        endcase
    endfunction

    // resistance ratio with saturation, returns the over flag
    function automatic logic ratio_over(input longint first, input longint second,
                                        input logic first_ovr, input int up, input int down,
                                        output logic [ame_pkg::VALUE_W-1:0] val);
        longint dv, m;
        dv = (second == 0) ? 64'sd1 : second;
        m  = first * cfg_ref;
        m  = m <<< (up & 15);
        m  = m / dv;
        m  = m >>> (down & 15);
        if (m < 0)
            m = -m;
        if (first_ovr || (m >>> 32) != 0) begin
            val = ame_pkg::SAT_VALUE;
            return 1'b1;
        end
        val = m[ame_pkg::VALUE_W-1:0];
        return 1'b0;
    endfunction

    function automatic reading_t predict_reading(input logic [ame_pkg::SAMPLE_W-1:0] smp,
                                                 input logic ovr);
        reading_t                    r;
        longint                      s, d, uv;
        logic                        lo, hi;
        logic [ame_pkg::VALUE_W-1:0] val;
        s  = $signed(smp);
        d  = (s < 0) ? -s : s;
        lo = d < cfg_low;
        hi = d > cfg_high;
        r  = '0;
        if (cfg_mode == ame_pkg::MODE_VOLT_AUTO) begin
            uv = (s * cfg_fs) >>> (ame_pkg::SAMPLE_FRACTION_BITS + (gain_first_applied & 15));
            r.value = uv[ame_pkg::VALUE_W-1:0];
            r.over  = ovr;
            r.ready = 1'b1;
            if (lo) begin
                if (gain_first_next < ame_pkg::MAX_GAIN_FIRST)
                    gain_first_next++;
            end else if (hi) begin
                if (gain_first_next > 0)
                    gain_first_next--;
            end
            gain_first_applied = gain_first_next;
            pair_phase = 1'b0;
            r.g1 = 4'(gain_first_next);
        end else if (!pair_phase) begin
            held_sample = s;
            held_over   = ovr;
            if (cfg_mode == ame_pkg::MODE_RES_AUTO) begin
                if (lo) begin
                    if (excitation_next >= ame_pkg::MAX_EXCITATION) begin
                        if (gain_first_next < ame_pkg::MAX_GAIN_FIRST)
                            gain_first_next++;
                    end else begin
                        excitation_next++;
                    end
                end else if (hi) begin
                    if (gain_first_next == 0) begin
                        if (excitation_next > ame_pkg::MIN_EXCITATION)
                            excitation_next--;
                    end else begin
                        gain_first_next--;
                    end
                end
            end
            pair_phase = 1'b1;
        end else begin
            case (cfg_mode)
                ame_pkg::MODE_RES_AUTO: begin
                    if (lo) begin
                        if (gain_second_next < ame_pkg::MAX_GAIN_SECOND)
                            gain_second_next++;
                    end else if (hi) begin
                        if (gain_second_next > 0)
                            gain_second_next--;
                    end
                    r.over = ratio_over(held_sample, s, held_over, gain_second_applied,
                                        gain_first_applied, val);
                    gain_first_applied  = gain_first_next;
                    gain_second_applied = gain_second_next;
                end
                ame_pkg::MODE_RES_SHORT:
                    r.over = ratio_over(held_sample, s, held_over, ame_pkg::MAX_GAIN_SECOND,
                                        ame_pkg::MAX_GAIN_FIRST, val);
                default:
                    r.over = ratio_over(held_sample, s, held_over, ame_pkg::MAX_GAIN_FIRST,
                                        0, val);
            endcase
            r.value = val;
            r.ready = 1'b1;
            pair_phase = 1'b0;
        end
        case (cfg_mode)
            ame_pkg::MODE_RES_AUTO: begin
                r.g1  = 4'(gain_first_next);
                r.g2  = 2'(gain_second_next);
                r.exc = 3'(excitation_next);
            end
            ame_pkg::MODE_RES_SHORT: begin
                r.g1  = 4'(ame_pkg::MAX_GAIN_FIRST);
                r.g2  = 2'(ame_pkg::MAX_GAIN_SECOND);
                r.exc = 3'(ame_pkg::MAX_EXCITATION);
            end
            ame_pkg::MODE_RES_OPEN:
                r.g1 = pair_phase ? 4'(ame_pkg::MAX_GAIN_FIRST) : 4'd0;
            default: ;
        endcase
        r.ph = pair_phase;
        return r;
    endfunction

    function automatic logic [ame_pkg::SAMPLE_W-1:0] pick_sample();
        longint                       mag;
        logic [ame_pkg::SAMPLE_W-1:0] v;
        mag = -1;
        v   = ame_pkg::SAMPLE_W'($urandom);
        case ($urandom_range(0, 7))
            2: mag = $urandom_range(0, 3000);
            3: mag = cfg_low + longint'($urandom_range(0, 4)) - 2;
            4: mag = cfg_high + longint'($urandom_range(0, 4)) - 2;
            5: begin
                case ($urandom_range(0, 3))
                    0: v = 24'h7fffff;
                    1: v = 24'h800000;
                    2: v = 24'h000000;
                    default: v = 24'hffffff;
                endcase
            end
            default: ;
        endcase
        if (mag >= 0 || (mag < -1)) begin
            if (mag < 0)
                mag = 0;
            if (mag > 64'sd8388607)
                mag = 64'sd8388607;
            v = mag[ame_pkg::SAMPLE_W-1:0];
            if ($urandom_range(0, 1))
                v = -v;
        end
        return v;
    endfunction

    task automatic check_field(input string name, input logic [ame_pkg::VALUE_W-1:0] want,
                               input logic [ame_pkg::VALUE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic add_row(input logic wr, input ame_pkg::mode_t m,
                           input logic [ame_pkg::SAMPLE_W-1:0] smp,
                           input logic ovr, input logic known, input reading_t typed);
        stim_row_t row;
        row.wr_mode = wr;
        row.mode    = m;
        row.smp     = smp;
        row.ovr     = ovr;
        row.known   = known;
        row.typed   = typed;
        stim_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [ame_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [ame_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_readings.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        meter_cfg(addr, data);
        reg_writes++;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic send_item(input logic [ame_pkg::SAMPLE_W-1:0] smp, input logic ovr,
                             input logic known, input reading_t typed);
        int       gap;
        reading_t r;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = smp;
        s_tuser  = ovr;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        r = predict_reading(smp, ovr);
        pending_readings.push_back(known ? typed : r);
        items_sent++;
    endtask

    // result side: short random stalls, two long hold-offs
    initial begin
        int hold, taken;
        hold     = 0;
        taken    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_tready = 1'b0;
                hold--;
            end else begin
                m_tready = 1'b1;
            end
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                taken++;
                if (taken == 200 || taken == 600)
                    hold = LONG_HOLD;
                else
                    hold = idle_on ? $urandom_range(0, 3) : 0;
            end
        end
    end

    always @(posedge aclk) begin
        reading_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.value = m_tdata[31:0];
            got.g1    = m_tdata[35:32];
            got.g2    = m_tdata[37:36];
            got.exc   = m_tdata[40:38];
            got.ph    = m_tdata[41];
            got.over  = m_tuser;
            got.ready = m_tlast;
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %0h", $time, got);
                errors++;
            end else begin
                want = pending_readings.pop_front();
                check_field("value", want.value, got.value);
                check_field("over", want.over, got.over);
                check_field("ready_res", want.ready, got.ready);
                check_field("next_gain_first", want.g1, got.g1);
                check_field("next_gain_second", want.g2, got.g2);
                check_field("next_excitation", want.exc, got.exc);
                check_field("next_phase", want.ph, got.ph);
                results_checked++;
                if (got.ready)
                    readings_done++;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_readings.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int                             k;
        ame_pkg::mode_t                 pm;
        logic [ame_pkg::CFG_DATA_W-1:0] lo_thr, hi_thr, ref_val, fs_val;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = ame_pkg::REG_MODE;
        cfg_wdata = '0;
        idle_on   = 1'b1;
        errors    = 0;
        items_sent = 0;
        results_checked = 0;
        readings_done = 0;
        reg_writes = 0;

        cfg_mode = ame_pkg::MODE_VOLT_AUTO;
        cfg_low  = ame_pkg::LOW_THR_RESET;
        cfg_high = ame_pkg::HIGH_THR_RESET;
        cfg_ref  = ame_pkg::REF_RESET;
        cfg_fs   = ame_pkg::FULL_SCALE_RESET;
        meter_clear();

        // voltage at reset settings
        add_row(1'b0, ame_pkg::MODE_VOLT_AUTO, 24'h000000, 1'b0, 1'b1,
                '{32'd0, 1'b0, 1'b1, 4'd1, 2'd0, 3'd0, 1'b0});
        add_row(1'b0, ame_pkg::MODE_VOLT_AUTO, 24'h7fffff, 1'b0, 1'b0, NO_READING);
        add_row(1'b0, ame_pkg::MODE_VOLT_AUTO, 24'h800000, 1'b1, 1'b0, NO_READING);
        add_row(1'b0, ame_pkg::MODE_VOLT_AUTO, 24'hffffff, 1'b0, 1'b0, NO_READING);
        add_row(1'b0, ame_pkg::MODE_VOLT_AUTO, 24'h000001, 1'b1, 1'b0, NO_READING);
        // short: first sample overrange saturates, zero divisor, extremes
        add_row(1'b1, ame_pkg::MODE_RES_SHORT, 24'd1000, 1'b1, 1'b1,
                '{32'd0, 1'b0, 1'b0, 4'(ame_pkg::MAX_GAIN_FIRST),
                  2'(ame_pkg::MAX_GAIN_SECOND), 3'(ame_pkg::MAX_EXCITATION), 1'b1});
        add_row(1'b0, ame_pkg::MODE_RES_SHORT, 24'd5, 1'b0, 1'b1,
                '{ame_pkg::SAT_VALUE, 1'b1, 1'b1, 4'(ame_pkg::MAX_GAIN_FIRST),
                  2'(ame_pkg::MAX_GAIN_SECOND), 3'(ame_pkg::MAX_EXCITATION), 1'b0});
        add_row(1'b0, ame_pkg::MODE_RES_SHORT, 24'h7fffff, 1'b0, 1'b0, NO_READING);
        add_row(1'b0, ame_pkg::MODE_RES_SHORT, 24'h000000, 1'b0, 1'b0, NO_READING);
        add_row(1'b0, ame_pkg::MODE_RES_SHORT, 24'h800000, 1'b0, 1'b0, NO_READING);
        add_row(1'b0, ame_pkg::MODE_RES_SHORT, 24'h800000, 1'b1, 1'b0, NO_READING);
        // open
        add_row(1'b1, ame_pkg::MODE_RES_OPEN, 24'd4000, 1'b0, 1'b1,
                '{32'd0, 1'b0, 1'b0, 4'(ame_pkg::MAX_GAIN_FIRST), 2'd0, 3'd0, 1'b1});
        add_row(1'b0, ame_pkg::MODE_RES_OPEN, 24'd3, 1'b0, 1'b0, NO_READING);
        add_row(1'b0, ame_pkg::MODE_RES_OPEN, 24'hfffb2e, 1'b0, 1'b0, NO_READING);
        add_row(1'b0, ame_pkg::MODE_RES_OPEN, 24'd77, 1'b1, 1'b0, NO_READING);
        // auto resistance, rewrite of the same mode mid-pair keeps state
        add_row(1'b1, ame_pkg::MODE_RES_AUTO, 24'd100, 1'b0, 1'b0, NO_READING);
        add_row(1'b0, ame_pkg::MODE_RES_AUTO, 24'd100, 1'b0, 1'b0, NO_READING);
        add_row(1'b0, ame_pkg::MODE_RES_AUTO, 24'd8000000, 1'b0, 1'b0, NO_READING);
        add_row(1'b1, ame_pkg::MODE_RES_AUTO, 24'd8000000, 1'b1, 1'b0, NO_READING);
        add_row(1'b0, ame_pkg::MODE_RES_AUTO, 24'h800000, 1'b1, 1'b0, NO_READING);
        add_row(1'b0, ame_pkg::MODE_RES_AUTO, 24'd12345, 1'b0, 1'b0, NO_READING);
        add_row(1'b1, ame_pkg::MODE_VOLT_AUTO, 24'd5872026, 1'b0, 1'b0, NO_READING);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].wr_mode)
                write_reg(ame_pkg::REG_MODE, ame_pkg::CFG_DATA_W'(stim_rows[i].mode));
            send_item(stim_rows[i].smp, stim_rows[i].ovr, stim_rows[i].known,
                      stim_rows[i].typed);
        end

        for (k = 0; k < PHASES; k++) begin
            pm = ame_pkg::mode_t'(k % 4);
            case (k % 5)
                0: begin
                    lo_thr = ame_pkg::LOW_THR_RESET;
                    hi_thr = ame_pkg::HIGH_THR_RESET;
                end
                1: begin
                    lo_thr = '0;
                    hi_thr = 23'h7fffff;
                end
                2: begin
                    lo_thr = 23'h7fffff;
                    hi_thr = '0;
                end
                3: begin
                    lo_thr = ame_pkg::CFG_DATA_W'($urandom_range(0, 4000000));
                    hi_thr = ame_pkg::CFG_DATA_W'(lo_thr + $urandom_range(0, 4000000));
                end
                default: begin
                    lo_thr = ame_pkg::CFG_DATA_W'($urandom);
                    hi_thr = ame_pkg::CFG_DATA_W'($urandom);
                end
            endcase
            case (k % 6)
                1: ref_val = 23'd1000000;
                2: ref_val = 23'd1;
                3: ref_val = '0;
                4: ref_val = 23'h7fffff;
                5: ref_val = ame_pkg::CFG_DATA_W'($urandom);
                default: ref_val = ame_pkg::CFG_DATA_W'($urandom_range(1, 1000000));
            endcase
            case (k % 7)
                1: fs_val = 23'd4000000;
                2: fs_val = 23'd1;
                3: fs_val = '0;
                4: fs_val = 23'h7fffff;
                5: fs_val = ame_pkg::CFG_DATA_W'($urandom);
                6: fs_val = ame_pkg::FULL_SCALE_RESET;
                default: fs_val = ame_pkg::CFG_DATA_W'($urandom_range(1, 4000000));
            endcase
            write_reg(ame_pkg::REG_MODE, {21'($urandom), pm});
            write_reg(ame_pkg::REG_LOW_THR, lo_thr);
            write_reg(ame_pkg::REG_HIGH_THR, hi_thr);
            write_reg(ame_pkg::REG_REF, ref_val);
            write_reg(ame_pkg::REG_FULL_SCALE, fs_val);
            if (k == 5)
                write_reg(REG_SPARE, ame_pkg::CFG_DATA_W'($urandom));
            idle_on = (k % 3 != 2);
            repeat (PHASE_ITEMS)
                send_item(pick_sample(), $urandom_range(0, 7) == 0, 1'b0, NO_READING);
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_readings.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d items sent, %0d results checked, %0d complete readings", items_sent,
                 results_checked, readings_done);
        $display("all four meter modes, %0d register writes incl. extreme settings, %0d cycles",
                 reg_writes, cycle_count);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/ame_pkg.sv
sv/ame_ctrl.sv
sv/ame_dp.sv
sv/autorange_meter_engine.sv
verif/autorange_meter_engine_tb.sv
